// ===== hw/rtl/tle_pkg.sv =====
package tle_pkg;

    // Key codes
    localparam logic [7:0] KEY_BS      = 8'h08;
    localparam logic [7:0] KEY_LF      = 8'h0A;
    localparam logic [7:0] KEY_CR      = 8'h0D;
    localparam logic [7:0] KEY_ESC     = 8'h1B;
    localparam logic [7:0] KEY_SPACE   = 8'h20;
    localparam logic [7:0] KEY_BRACKET = 8'h5B;
    localparam logic [7:0] CSI_UP      = 8'h41;
    localparam logic [7:0] CSI_DOWN    = 8'h42;
    localparam logic [7:0] CSI_FWD     = 8'h43;
    localparam logic [7:0] CSI_BACK    = 8'h44;
    localparam logic [7:0] KEY_DEL     = 8'h7F;
    localparam logic [7:0] KEY_IGNORE  = 8'hFF;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    // Input op codes
    typedef enum logic {
        OP_KEY  = 1'b0,
        OP_READ = 1'b1
    } t_op;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_READY = 2'd1,
        KIND_OVFL  = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    // Escape sequence phase
    typedef enum logic [1:0] {
        ESC_IDLE    = 2'd0,
        ESC_SEEN    = 2'd1,
        ESC_BRACKET = 2'd2
    } t_esc;

    // Work handed from front to back
    typedef enum logic [2:0] {
        ACT_ECHO  = 3'd0,   // echo one byte
        ACT_ARROW = 3'd1,   // echo ESC [ byte
        ACT_ERASE = 3'd2,   // echo BS SP BS
        ACT_LINE  = 3'd3,   // echo CR LF, then line ready
        ACT_OVFL  = 3'd4,   // overflow report
        ACT_READ  = 3'd5    // read data
    } t_act;

    typedef struct packed {
        t_act       act;
        logic [7:0] data;
        logic [7:0] len;
    } t_cmd;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] len;
        logic       last;
    } t_res;

endpackage

// ===== hw/rtl/tle_ram.sv =====
module tle_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 256
    )
    (
        input  logic                     i_clk,
        input  logic                     i_we,
        input  logic [$clog2(DEPTH)-1:0] i_addr,
        input  logic [WIDTH-1:0]         i_wdata,
        output logic [WIDTH-1:0]         o_rdata
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tle_front.sv =====
module tle_front
    import tle_pkg::*;
    #(
        parameter int LINE_BYTES = 256
    )
    (
        input  logic                  i_clk,
        input  logic                  i_rst_n,
        input  logic                  i_valid,
        output logic                  o_ready,
        input  logic                  i_op,
        input  logic [7:0]            i_key_byte,
        input  logic [7:0]            i_read_index,
        input  logic [QUEUE_CW-1:0]   i_queue_level,
        output logic                  o_push,
        output t_cmd                  o_push_cmd
    );

    localparam int AW = $clog2(LINE_BYTES);
    localparam int CW = (AW > 8) ? AW : 8;
    localparam logic [AW-1:0] LAST_SLOT = AW'(LINE_BYTES - 1);

    logic [AW-1:0] r_cursor, n_cursor;
    logic [AW-1:0] r_line_end, n_line_end;
    logic [AW-1:0] r_done_len, n_done_len;
    t_esc          r_esc, n_esc;

    logic          r_s1_valid;
    t_cmd          r_s1_cmd;
    logic          r_s1_hit;

    logic          accept;
    logic          cmd_valid;
    t_cmd          cmd;
    logic          hit;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_rdata;

    logic [AW+7:0] end_wide;
    logic [AW+7:0] idx_wide;
    logic [CW-1:0] idx_cmp;
    logic [CW-1:0] done_cmp;

    // Room for this item and one still in the stage register
    assign o_ready = ({1'b0, i_queue_level} + {{QUEUE_CW{1'b0}}, r_s1_valid})
                     < (QUEUE_CW+1)'(QUEUE_DEPTH);
    assign accept  = i_valid && o_ready;

    assign end_wide = {8'd0, r_line_end};
    assign idx_wide = {{AW{1'b0}}, i_read_index};
    assign idx_cmp  = CW'({{AW{1'b0}}, i_read_index});
    assign done_cmp = CW'({8'd0, r_done_len});

    // Edit state and command decode
    always_comb begin
        n_cursor   = r_cursor;
        n_line_end = r_line_end;
        n_done_len = r_done_len;
        n_esc      = r_esc;
        cmd_valid  = 1'b0;
        cmd.act    = ACT_ECHO;
        cmd.data   = i_key_byte;
        cmd.len    = 8'd0;
        hit        = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = r_cursor;

        if (t_op'(i_op) == OP_READ) begin
            cmd_valid = 1'b1;
            cmd.act   = ACT_READ;
            mem_addr  = idx_wide[AW-1:0];
            hit       = idx_cmp < done_cmp;
        end else if (i_key_byte != KEY_IGNORE) begin
            unique case (r_esc)
                ESC_SEEN: begin
                    n_esc = (i_key_byte == KEY_BRACKET) ? ESC_BRACKET : ESC_IDLE;
                end
                ESC_BRACKET: begin
                    n_esc = ESC_IDLE;
                    if (i_key_byte == CSI_FWD && r_cursor < r_line_end) begin
                        n_cursor  = r_cursor + AW'(1);
                        cmd_valid = 1'b1;
                        cmd.act   = ACT_ARROW;
                    end else if (i_key_byte == CSI_BACK && r_cursor != '0) begin
                        n_cursor  = r_cursor - AW'(1);
                        cmd_valid = 1'b1;
                        cmd.act   = ACT_ARROW;
                    end
                end
                default: begin
                    priority if (i_key_byte == KEY_CR) begin
                        n_done_len = r_line_end;
                        n_cursor   = '0;
                        n_line_end = '0;
                        cmd_valid  = 1'b1;
                        cmd.act    = ACT_LINE;
                        cmd.len    = end_wide[7:0];
                    end else if (i_key_byte == KEY_ESC) begin
                        n_esc = ESC_SEEN;
                    end else if (i_key_byte == KEY_BS || i_key_byte == KEY_DEL) begin
                        if (r_cursor != '0) begin
                            n_cursor   = r_cursor - AW'(1);
                            n_line_end = r_cursor - AW'(1);
                            cmd_valid  = 1'b1;
                            cmd.act    = ACT_ERASE;
                        end
                    end else if (r_cursor >= LAST_SLOT) begin
                        // Typing into the last slot drops the line
                        mem_we     = 1'b1;
                        mem_addr   = LAST_SLOT;
                        n_cursor   = '0;
                        n_line_end = '0;
                        cmd_valid  = 1'b1;
                        cmd.act    = ACT_OVFL;
                    end else begin
                        mem_we     = 1'b1;
                        n_cursor   = r_cursor + AW'(1);
                        n_line_end = r_cursor + AW'(1);
                        cmd_valid  = 1'b1;
                        cmd.act    = ACT_ECHO;
                    end
                end
            endcase
        end
    end

    tle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BYTES)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (accept && mem_we),
        .i_addr  (mem_addr),
        .i_wdata (i_key_byte),
        .o_rdata (mem_rdata)
    );

    // Edit state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor   <= '0;
            r_line_end <= '0;
            r_done_len <= '0;
            r_esc      <= ESC_IDLE;
        end else if (accept) begin
            r_cursor   <= n_cursor;
            r_line_end <= n_line_end;
            r_done_len <= n_done_len;
            r_esc      <= n_esc;
        end
    end

    // Stage register waits for the line RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept && cmd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_cmd <= cmd;
        r_s1_hit <= hit;
    end

    // Read data is zero past the completed line
    always_comb begin
        o_push_cmd = r_s1_cmd;
        if (r_s1_cmd.act == ACT_READ) begin
            o_push_cmd.data = r_s1_hit ? mem_rdata : 8'd0;
        end
    end

    assign o_push = r_s1_valid;

endmodule

// ===== hw/rtl/tle_queue.sv =====
module tle_queue
    import tle_pkg::*;
    (
        input  logic                i_clk,
        input  logic                i_rst_n,
        input  logic                i_push,
        input  t_cmd                i_push_cmd,
        input  logic                i_pop,
        output logic                o_valid,
        output t_cmd                o_head,
        output logic [QUEUE_CW-1:0] o_level
    );

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_pop;

    // Front holds off when full, so a push always fits
    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QUEUE_CW'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - QUEUE_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign o_level = r_count;

endmodule

// ===== hw/rtl/tle_back.sv =====
module tle_back
    import tle_pkg::*;
    (
        input  logic i_clk,
        input  logic i_rst_n,
        input  logic i_cmd_valid,
        input  t_cmd i_cmd,
        output logic o_pop,
        output logic o_valid,
        input  logic i_ready,
        output t_res o_res
    );

    logic       r_cur_valid;
    t_cmd       r_cur;
    logic [1:0] r_step;
    logic       r_out_valid;
    t_res       r_out;

    t_res       res;
    logic       gen;
    logic       finish;
    logic       pop;

    // Expand one command into its result items
    always_comb begin
        res.kind = KIND_ECHO;
        res.data = r_cur.data;
        res.len  = 8'd0;
        res.last = 1'b1;
        unique case (r_cur.act)
            ACT_ECHO: begin
                res.kind = KIND_ECHO;
            end
            ACT_ARROW: begin
                res.last = r_step == 2'd2;
                unique case (r_step)
                    2'd0:    res.data = KEY_ESC;
                    2'd1:    res.data = KEY_BRACKET;
                    default: res.data = r_cur.data;
                endcase
            end
            ACT_ERASE: begin
                res.last = r_step == 2'd2;
                res.data = (r_step == 2'd1) ? KEY_SPACE : KEY_BS;
            end
            ACT_LINE: begin
                res.last = r_step == 2'd2;
                unique case (r_step)
                    2'd0:    res.data = KEY_CR;
                    2'd1:    res.data = KEY_LF;
                    default: begin
                        res.kind = KIND_READY;
                        res.data = 8'd0;
                        res.len  = r_cur.len;
                    end
                endcase
            end
            ACT_OVFL: begin
                res.kind = KIND_OVFL;
                res.data = 8'd0;
            end
            ACT_READ: begin
                res.kind = KIND_READ;
            end
            default: begin
                res.kind = KIND_ECHO;
            end
        endcase
    end

    assign gen    = r_cur_valid && (!r_out_valid || i_ready);
    assign finish = gen && res.last;
    assign pop    = i_cmd_valid && (!r_cur_valid || finish);
    assign o_pop  = pop;

    // Current command and step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_step      <= 2'd0;
        end else begin
            if (pop) begin
                r_cur_valid <= 1'b1;
                r_step      <= 2'd0;
            end else if (finish) begin
                r_cur_valid <= 1'b0;
            end else if (gen) begin
                r_step <= r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur <= i_cmd;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (gen) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen) begin
            r_out <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

// ===== hw/rtl/terminal_line_editor.sv =====
// Terminal line editor.
// Slave stream: one item per key byte (tuser = 0, tdata[7:0] = key) or per read
// of the completed line (tuser = 1, tdata[15:8] = index). Master stream: result
// items, tuser = kind (echo, line ready, overflow, read data), tdata = data
// byte and line length, tlast on the final result of each input item.
// Each item causes zero to three results; echoes of arrows, backspace and
// carriage return give three, plain bytes and reads give one.
// The first result passes the front's stage register, the command queue and the
// back's command and output registers. The front edits one item per cycle while
// the queue has room; the back puts out one result per cycle while not stalled.
// A 4-entry command queue sits between them; the input stalls only when that
// queue, counting the item in the front's stage register, is full.
// The line buffer is a single-port RAM of LINE_BYTES bytes, read and written
// by the front in input order, so a read below the completed length sees all earlier writes.
// Reset clears cursor, line length, escape phase, completed length and the
// queues; the line RAM is not cleared. When the receiver stalls, the held
// result stays stable and the queue absorbs further items until full.
module terminal_line_editor
    import tle_pkg::*;
    #(
        parameter int LINE_BYTES = 256
    )
    (
        input  logic        i_clk,
        input  logic        i_rst_n,
        input  logic        i_s_axis_tvalid,
        output logic        o_s_axis_tready,
        input  logic [15:0] i_s_axis_tdata,   // key_byte[7:0], read_index[15:8]
        input  logic        i_s_axis_tuser,   // op[0]
        output logic        o_m_axis_tvalid,
        input  logic        i_m_axis_tready,
        output logic [15:0] o_m_axis_tdata,   // data_byte[7:0], line_length[15:8]
        output logic [1:0]  o_m_axis_tuser,   // kind[1:0]
        output logic        o_m_axis_tlast
    );

    logic                push;
    t_cmd                push_cmd;
    logic                pop;
    logic                head_valid;
    t_cmd                head;
    logic [QUEUE_CW-1:0] level;
    t_res                res;

    tle_front #(
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_op          (i_s_axis_tuser),
        .i_key_byte    (i_s_axis_tdata[7:0]),
        .i_read_index  (i_s_axis_tdata[15:8]),
        .i_queue_level (level),
        .o_push        (push),
        .o_push_cmd    (push_cmd)
    );

    tle_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_valid    (head_valid),
        .o_head     (head),
        .o_level    (level)
    );

    tle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head),
        .o_pop       (pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_res       (res)
    );

    assign o_m_axis_tdata = {res.len, res.data};
    assign o_m_axis_tuser = res.kind;
    assign o_m_axis_tlast = res.last;

endmodule
